// File: rtl/core/hufd_pkg.sv
`default_nettype none

package hufd_pkg;

  // Fixed field widths of the item payloads.
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned CNT_W     = 4;

  // Item kinds on the input channel.
  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Bits a data item can consume at most.
  localparam logic [CNT_W-1:0] MAX_BITS = CNT_W'(BYTE_BITS);

  // One entry of the node table.
  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  // Walk sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } walk_state_e;

endpackage

`default_nettype wire

// File: rtl/core/hufd_if.sv
`default_nettype none

// Input channel: node writes and compressed data bytes.
interface hufd_in_if import hufd_pkg::*;;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [IDX_W-1:0] node_index;
  logic             node_is_leaf;
  logic [SYM_W-1:0] node_symbol;
  logic [IDX_W-1:0] left_child;
  logic [IDX_W-1:0] right_child;
  logic [SYM_W-1:0] data_byte;
  logic [CNT_W-1:0] bit_count;

  modport source (
    output valid, kind, node_index, node_is_leaf, node_symbol,
           left_child, right_child, data_byte, bit_count,
    input  ready
  );

  modport sink (
    input  valid, kind, node_index, node_is_leaf, node_symbol,
           left_child, right_child, data_byte, bit_count,
    output ready
  );
endinterface

// Output channel: decoded symbols.
interface hufd_out_if import hufd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (
    output valid, symbol, last,
    input  ready
  );

  modport sink (
    input  valid, symbol, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/hufd_node_mem.sv
`default_nettype none

// Node table: one write port, one read port, registered read data.
module hufd_node_mem import hufd_pkg::*; #(
  parameter int unsigned NODE_ENTRIES = 512
) (
  input  wire logic                            clk_i,
  input  wire logic                            wr_en_i,
  input  wire logic [$clog2(NODE_ENTRIES)-1:0] wr_addr_i,
  input  wire node_t                           wr_data_i,
  input  wire logic                            rd_en_i,
  input  wire logic [$clog2(NODE_ENTRIES)-1:0] rd_addr_i,
  output node_t                                rd_data_o
);

  node_t mem_q [NODE_ENTRIES];
  node_t rd_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data register holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// File: rtl/core/hufd_walk_ctrl.sv
`default_nettype none

// Tree walk sequencer: one node-table read per consumed bit.
module hufd_walk_ctrl import hufd_pkg::*; #(
  parameter int unsigned NODE_ENTRIES = 512
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  hufd_in_if.sink                              in_i,
  hufd_out_if.source                           out_o,
  output logic                                 wr_en_o,
  output logic [$clog2(NODE_ENTRIES)-1:0]      wr_addr_o,
  output node_t                                wr_data_o,
  output logic                                 rd_en_o,
  output logic [$clog2(NODE_ENTRIES)-1:0]      rd_addr_o,
  input  wire node_t                           rd_data_i
);

  localparam int unsigned AddrW = $clog2(NODE_ENTRIES);

  walk_state_e      state_q, state_d;
  logic [CNT_W-1:0] bits_q, bits_d;
  logic [SYM_W-1:0] shreg_q, shreg_d;
  logic             at_root_q, at_root_d;
  logic             arrived_q, arrived_d;
  logic             pend_ok_q, pend_ok_d;
  logic [SYM_W-1:0] pend_sym_q, pend_sym_d;
  node_t            root_q, root_d;
  logic             out_valid_q, out_valid_d;
  logic [SYM_W-1:0] out_sym_q, out_sym_d;
  logic             out_last_q, out_last_d;

  logic             leaf_hit;
  node_t            step_node;
  logic [IDX_W-1:0] next_idx;
  logic             next_ok;
  logic             final_bit;
  logic             out_free;
  logic             need_push;
  logic             advance;
  logic             in_fire;
  logic             push;
  logic [SYM_W-1:0] push_sym;
  logic             push_last;
  node_t            new_node;

  // The read data register holds the node just stepped to; a leaf there
  // is held pending and the step of the same cycle starts again from the root.
  assign leaf_hit  = arrived_q && rd_data_i.leaf;
  assign step_node = (at_root_q || leaf_hit) ? root_q : rd_data_i;
  assign next_idx  = shreg_q[SYM_W-1] ? step_node.right : step_node.left;
  assign next_ok   = 32'(next_idx) < 32'(NODE_ENTRIES);
  assign final_bit = (bits_q == '0);
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_fire   = in_i.valid && in_i.ready;
  assign advance   = !need_push || out_free;

  assign new_node = '{leaf:   in_i.node_is_leaf,
                      symbol: in_i.node_symbol,
                      left:   in_i.left_child,
                      right:  in_i.right_child};

  // Whether this cycle must hand an item to the output register.
  always_comb begin
    case (state_q)
      ST_RUN: begin
        if (final_bit) begin
          need_push = leaf_hit || pend_ok_q;
        end else begin
          need_push = leaf_hit && pend_ok_q;
        end
      end
      ST_FLUSH: need_push = 1'b1;
      default:  need_push = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_i.kind == KIND_DATA) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance && final_bit) begin
          state_d = (leaf_hit && pend_ok_q) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory requests and output pushes.
  always_comb begin
    bits_d     = bits_q;
    shreg_d    = shreg_q;
    at_root_d  = at_root_q;
    arrived_d  = arrived_q;
    pend_ok_d  = pend_ok_q;
    pend_sym_d = pend_sym_q;
    root_d     = root_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = AddrW'(in_i.node_index);
    wr_data_o  = new_node;
    rd_en_o    = 1'b0;
    rd_addr_o  = AddrW'(next_idx);
    push       = 1'b0;
    push_sym   = pend_sym_q;
    push_last  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.kind == KIND_NODE) begin
            // A node write lands in the table and sends the walk home.
            wr_en_o   = 32'(in_i.node_index) < 32'(NODE_ENTRIES);
            at_root_d = 1'b1;
            arrived_d = 1'b0;
            if (in_i.node_index == '0) begin
              root_d = new_node;
            end
          end else begin
            bits_d  = in_i.bit_count[CNT_W-1] ? MAX_BITS : in_i.bit_count;
            shreg_d = in_i.data_byte;
          end
        end
      end
      ST_RUN: begin
        if (advance) begin
          // A symbol found earlier goes out once the next one shows up.
          if (leaf_hit) begin
            if (pend_ok_q) begin
              push = 1'b1;
            end
            pend_sym_d = rd_data_i.symbol;
            pend_ok_d  = 1'b1;
          end
          if (final_bit) begin
            // Close the item: the newest symbol carries the last flag.
            at_root_d = at_root_q || leaf_hit;
            arrived_d = 1'b0;
            if (leaf_hit && !pend_ok_q) begin
              push      = 1'b1;
              push_sym  = rd_data_i.symbol;
              push_last = 1'b1;
              pend_ok_d = 1'b0;
            end else if (!leaf_hit && pend_ok_q) begin
              push      = 1'b1;
              push_last = 1'b1;
              pend_ok_d = 1'b0;
            end
          end else begin
            // Consume one bit and fetch the child it selects.
            shreg_d = {shreg_q[SYM_W-2:0], 1'b0};
            bits_d  = bits_q - CNT_W'(1);
            if (next_ok) begin
              rd_en_o   = 1'b1;
              at_root_d = 1'b0;
              arrived_d = 1'b1;
            end else begin
              at_root_d = 1'b1;
              arrived_d = 1'b0;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          pend_ok_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_sym_d   = push_sym;
      out_last_d  = push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bits_q      <= '0;
      at_root_q   <= 1'b1;
      arrived_q   <= 1'b0;
      pend_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bits_q      <= bits_d;
      at_root_q   <= at_root_d;
      arrived_q   <= arrived_d;
      pend_ok_q   <= pend_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q    <= shreg_d;
    pend_sym_q <= pend_sym_d;
    root_q     <= root_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
  end

  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.symbol = out_sym_q;
  assign out_o.last   = out_last_q;

endmodule

`default_nettype wire

// File: rtl/core/huffman_tree_decoder.sv
// Channel   Role     Item
// --------  -------  ------------------------------------------------------
// in_i      sink     node write (kind 0) or data byte with bit count (kind 1)
// out_o     source   decoded symbol, last set on the final one of a byte
//
// A node write needs no walk. A data item walks bit_count bits (bit_count
// capped at 8), with a flush step added when its final bit completes a symbol
// after an earlier one: each bit costs one dependent read of the node memory.
// Reset clears the walk state only; the node memory is not cleared, and
// entries read before being written give undefined symbols.
// A full output register stalls the walk only while it has a symbol to push.
`default_nettype none

module huffman_tree_decoder import hufd_pkg::*; #(
  parameter int unsigned NODE_ENTRIES = 512
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hufd_in_if.sink     in_i,
  hufd_out_if.source  out_o
);

  localparam int unsigned AddrW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  node_t            wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  node_t            rd_data;

  // Walk sequencer.
  hufd_walk_ctrl #(
    .NODE_ENTRIES(NODE_ENTRIES)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data)
  );

  // Node table.
  hufd_node_mem #(
    .NODE_ENTRIES(NODE_ENTRIES)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

endmodule

`default_nettype wire

// File: rtl/core/hufd_checker.sv
`default_nettype none

module hufd_checker import hufd_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             in_kind_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [SYM_W-1:0] out_symbol_i,
  input wire logic             out_last_i
);

  // A result item waits until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  // A stalled result item keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_symbol_i) && $stable(out_last_i))
    else $error("output payload changed while stalled");

  // A data byte keeps the block busy for at least the next cycle.
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_kind_i == KIND_DATA |=> !in_ready_i)
    else $error("input taken again right after a data byte");

  // A node write finishes in its own cycle.
  a_node_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_kind_i == KIND_NODE |=> in_ready_i)
    else $error("node write held the input");

  // New symbols appear only from a walk in progress.
  a_out_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("symbol produced while the walk was idle");

endmodule

bind huffman_tree_decoder hufd_checker u_hufd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_symbol_i(out_o.symbol),
  .out_last_i  (out_o.last)
);

`default_nettype wire

// File: dv/huffman_tree_decoder_tb.sv
`timescale 1ns / 1ps

module huffman_tree_decoder_tb import hufd_pkg::*;;

  localparam int unsigned NODE_ENTRIES   = 512;
  localparam int unsigned HALF_PERIOD    = 4;
  localparam int unsigned MAX_GAP        = 10;
  localparam int unsigned RANDOM_ITEMS   = 150;
  localparam int unsigned DRAIN_CYCLES   = 32;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  // One item on the input channel, node write or data byte.
  typedef struct {
    logic             kind;
    logic [IDX_W-1:0] node_index;
    logic             node_is_leaf;
    logic [SYM_W-1:0] node_symbol;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic [SYM_W-1:0] data_byte;
    logic [CNT_W-1:0] bit_count;
  } in_item_t;

  // One decoded symbol as it should leave the block.
  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } symbol_result_t;

  logic clk_i;
  logic rst_ni;

  hufd_in_if  in_if ();
  hufd_out_if out_if ();

  huffman_tree_decoder #(
    .NODE_ENTRIES(NODE_ENTRIES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Shadow copy of the node table and the walk, plus the symbols still owed.
  node_t            node_mem [NODE_ENTRIES];
  bit               node_known [NODE_ENTRIES];
  int unsigned      known_nodes [$];
  logic [IDX_W-1:0] walk_pos;
  symbol_result_t   pending_symbols [$];

  bit               taken_in_tree [NODE_ENTRIES];
  bit               no_gaps;
  int unsigned      error_count;
  int unsigned      sent_count;
  int unsigned      idle_cycles;

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Walk the shadow tree over the valid bits of one data byte.
  function automatic void walk_shadow_bits(logic [SYM_W-1:0] bits,
                                           logic [CNT_W-1:0] count);
    int unsigned      n;
    logic [IDX_W-1:0] next;
    symbol_result_t   found [$];

    n = (count > MAX_BITS) ? 32'(MAX_BITS) : 32'(count);
    for (int unsigned k = 0; k < n; k++) begin
      next = bits[7-k] ? node_mem[walk_pos].right : node_mem[walk_pos].left;
      walk_pos = next;
      if (node_mem[next].leaf) begin
        found.insert(found.size(), '{symbol: node_mem[next].symbol, last: 1'b0});
        walk_pos = '0;
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) pending_symbols.insert(pending_symbols.size(), found[i]);
  endfunction

  // Apply one accepted item to the shadow state.
  function automatic void model_item(in_item_t it);
    if (it.kind == KIND_NODE) begin
      node_mem[it.node_index] = '{leaf: it.node_is_leaf, symbol: it.node_symbol,
                                  left: it.left_child, right: it.right_child};
      if (!node_known[it.node_index]) begin
        node_known[it.node_index] = 1'b1;
        known_nodes.insert(known_nodes.size(), 32'(it.node_index));
      end
      walk_pos = '0;
    end else begin
      walk_shadow_bits(it.data_byte, it.bit_count);
    end
  endfunction

  // Node write; the data-only fields carry random noise.
  function automatic in_item_t node_item(logic [IDX_W-1:0] idx, logic leaf,
                                         logic [SYM_W-1:0] sym,
                                         logic [IDX_W-1:0] lft, logic [IDX_W-1:0] rgt);
    in_item_t it;
    it.kind         = KIND_NODE;
    it.node_index   = idx;
    it.node_is_leaf = leaf;
    it.node_symbol  = sym;
    it.left_child   = lft;
    it.right_child  = rgt;
    it.data_byte    = SYM_W'($urandom_range(0, 255));
    it.bit_count    = CNT_W'($urandom_range(0, 15));
    return it;
  endfunction

  // Data byte; the node-only fields carry random noise.
  function automatic in_item_t data_item(logic [SYM_W-1:0] bits, logic [CNT_W-1:0] count);
    in_item_t it;
    it.kind         = KIND_DATA;
    it.node_index   = IDX_W'($urandom_range(0, NODE_ENTRIES-1));
    it.node_is_leaf = 1'($urandom_range(0, 1));
    it.node_symbol  = SYM_W'($urandom_range(0, 255));
    it.left_child   = IDX_W'($urandom_range(0, NODE_ENTRIES-1));
    it.right_child  = IDX_W'($urandom_range(0, NODE_ENTRIES-1));
    it.data_byte    = bits;
    it.bit_count    = count;
    return it;
  endfunction

  // A child must point at an entry already written, or at the node itself,
  // so that no walk ever reads an entry that holds nothing.
  function automatic logic [IDX_W-1:0] safe_child(logic [IDX_W-1:0] self);
    int unsigned r;
    r = $urandom_range(0, known_nodes.size());
    return (r == known_nodes.size()) ? self : IDX_W'(known_nodes[r]);
  endfunction

  function automatic logic [IDX_W-1:0] fresh_index();
    logic [IDX_W-1:0] idx;
    do idx = IDX_W'($urandom_range(1, NODE_ENTRIES-1)); while (taken_in_tree[idx]);
    taken_in_tree[idx] = 1'b1;
    return idx;
  endfunction

  // Send one item and update the shadow state once it is accepted.
  // Valid stays high after acceptance so back-to-back items need one update.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= it.kind;
    in_if.node_index   <= it.node_index;
    in_if.node_is_leaf <= it.node_is_leaf;
    in_if.node_symbol  <= it.node_symbol;
    in_if.left_child   <= it.left_child;
    in_if.right_child  <= it.right_child;
    in_if.data_byte    <= it.data_byte;
    in_if.bit_count    <= it.bit_count;
    do @(posedge clk_i); while (!in_if.ready);
    model_item(it);
    sent_count++;
  endtask

  // Build a random full binary tree bottom-up with its root at entry 0.
  task automatic grow_random_tree(int unsigned leaves);
    int unsigned      pool [$];
    int unsigned      pick;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] parent;

    taken_in_tree = '{default: 1'b0};
    for (int unsigned i = 0; i < leaves; i++) begin
      parent = fresh_index();
      send_item(node_item(parent, 1'b1, SYM_W'($urandom_range(0, 255)),
                          safe_child(parent), safe_child(parent)));
      pool.insert(pool.size(), 32'(parent));
    end
    while (pool.size() > 1) begin
      pick = $urandom_range(0, pool.size()-1);
      a    = IDX_W'(pool[pick]);
      pool.delete(pick);
      pick = $urandom_range(0, pool.size()-1);
      b    = IDX_W'(pool[pick]);
      pool.delete(pick);
      parent = (pool.size() == 0) ? '0 : fresh_index();
      send_item(node_item(parent, 1'b0, SYM_W'($urandom_range(0, 255)), a, b));
      pool.insert(pool.size(), 32'(parent));
    end
  endtask

  // Codes of the fixed tree: 0 -> FF, 10 -> 00, 11 -> A5.
  task automatic test_fixed_codes();
    send_item(node_item(9'd511, 1'b1, 8'hFF, 9'd511, 9'd511));
    send_item(node_item(9'd2, 1'b1, 8'h00, 9'd511, 9'd2));
    send_item(node_item(9'd3, 1'b1, 8'hA5, 9'd2, 9'd511));
    send_item(node_item(9'd1, 1'b0, 8'h00, 9'd2, 9'd3));
    send_item(node_item(9'd0, 1'b0, 8'hFF, 9'd511, 9'd1));
    send_item(data_item(8'h00, 4'd8));
    send_item(data_item(8'hFF, 4'd8));
  endtask

  // Zero, single and oversized bit counts, and codes split across bytes.
  task automatic test_bit_count_edges();
    send_item(data_item(8'hFF, 4'd0));
    send_item(data_item(8'hB0, 4'd1));
    send_item(data_item(8'h00, 4'd1));
    send_item(data_item(8'h80, 4'd15));
    send_item(data_item(8'h55, 4'd9));
    send_item(data_item(8'h3C, 4'd4));
  endtask

  // A node write in the middle of a code sends the walk back to the root.
  task automatic test_walk_restart();
    send_item(data_item(8'h80, 4'd1));
    send_item(node_item(9'd3, 1'b1, 8'h5A, 9'd2, 9'd511));
    send_item(data_item(8'hC0, 4'd2));
    send_item(data_item(8'h00, 4'd1));
  endtask

  // A root marked as a leaf still steps through its child fields.
  task automatic test_leaf_root();
    send_item(node_item(9'd0, 1'b1, 8'h77, 9'd511, 9'd1));
    send_item(data_item(8'h40, 4'd3));
    send_item(data_item(8'hE5, 4'd8));
    send_item(node_item(9'd0, 1'b0, 8'h00, 9'd511, 9'd1));
  endtask

  // Fresh random trees, each followed by a run of data bytes with some noise.
  task automatic test_random_trees();
    int unsigned start;
    int unsigned bytes;
    int unsigned roll;
    logic [IDX_W-1:0] idx;

    start = sent_count;
    while (sent_count - start < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      grow_random_tree(($urandom_range(0, 5) == 0) ? 24 : $urandom_range(2, 12));
      bytes = $urandom_range(20, 40);
      for (int unsigned i = 0; i < bytes && sent_count - start < RANDOM_ITEMS; i++) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
          idx = IDX_W'($urandom_range(0, NODE_ENTRIES-1));
          send_item(node_item(idx, 1'($urandom_range(0, 1)),
                              SYM_W'($urandom_range(0, 255)),
                              safe_child(idx), safe_child(idx)));
        end else if (roll == 1) begin
          send_item(data_item(SYM_W'($urandom_range(0, 255)),
                              CNT_W'(($urandom_range(0, 1) == 0) ?
                                     0 : $urandom_range(9, 15))));
        end else begin
          send_item(data_item(SYM_W'($urandom_range(0, 255)),
                              CNT_W'($urandom_range(1, 8))));
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  // Output side: a random stall before each item is taken.
  initial begin : result_sink
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Compare every accepted symbol with the oldest one owed.
  always @(posedge clk_i) begin : check_symbols
    symbol_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_symbols.size() == 0) begin
        report_mismatch($sformatf("symbol %02h arrived with none owed", out_if.symbol));
      end else begin
        want = pending_symbols.pop_front();
        if (out_if.symbol !== want.symbol)
          report_mismatch($sformatf("symbol %02h, wanted %02h", out_if.symbol, want.symbol));
        if (out_if.last !== want.last)
          report_mismatch($sformatf("last %b on symbol %02h, wanted %b",
                                    out_if.last, out_if.symbol, want.last));
      end
    end
  end

  // Stop the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[huffman_tree_decoder] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.kind         = KIND_NODE;
    in_if.node_index   = '0;
    in_if.node_is_leaf = 1'b0;
    in_if.node_symbol  = '0;
    in_if.left_child   = '0;
    in_if.right_child  = '0;
    in_if.data_byte    = '0;
    in_if.bit_count    = '0;
    idle_cycles        = 0;
    error_count        = 0;
    sent_count         = 0;
    no_gaps            = 1'b0;
    walk_pos           = '0;
    node_known         = '{default: 1'b0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_fixed_codes();
    test_bit_count_edges();
    test_walk_restart();
    test_leaf_root();
    test_random_trees();

    in_if.valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[huffman_tree_decoder] OK");
    end else begin
      $display("[huffman_tree_decoder] ERROR");
    end
    $finish;
  end

endmodule
